FILE: hw/rtl/ctpr_pkg.sv
// shared constants, types and helpers of the column top profile resampler
package ctpr_pkg;

    // sizes
    localparam int NUM_SAMPLES = 2048;
    localparam int NS_LOG2     = $clog2(NUM_SAMPLES);
    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int DIM_W       = 13;
    localparam int TOP_W       = 12;
    localparam int SAMPLE_W    = 11;
    localparam int RGB_W       = 24;
    localparam int HEIGHT_W    = 25;
    localparam int DHALF_W     = 15;
    localparam int RFRAC_W     = NS_LOG2 + 1;
    localparam int PROD_W      = DHALF_W + RFRAC_W;
    localparam int SUM_W       = PROD_W + 1;
    localparam int PMAP_W      = SAMPLE_W + DIM_W;

    // item modes
    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_PIXEL = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    // register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // register reset values
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd1024;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd512;

    // output saturation limits
    localparam logic signed [SUM_W-1:0] SUM_MAX = 28'sd16777215;
    localparam logic signed [SUM_W-1:0] SUM_MIN = -28'sd16777216;

    typedef logic [COL_W-1:0] col_t;
    typedef logic [DIM_W-1:0] dim_t;

    // one column store entry
    typedef struct packed {
        logic             found;
        logic [TOP_W-1:0] top;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // write request into the column store
    typedef struct packed {
        logic   en;
        col_t   addr;
        entry_t data;
    } mem_wr_t;

    // height of a column in half pixels: h - 2*top, empty column reads as top = h
    function automatic logic signed [DHALF_W-1:0] half_height(entry_t e, dim_t h);
        logic [DIM_W-1:0] top;
        top = e.found ? {1'b0, e.top} : h;
        return $signed({2'b00, h}) - $signed({1'b0, top, 1'b0});
    endfunction

endpackage

FILE: hw/rtl/ctpr_ram.sv
// generic single write, single read RAM with registered read data
module ctpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/ctpr_raster.sv
// raster position tracking and first-row capture for pixel items
module ctpr_raster (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pixel_accept,
    input  logic                              clear_accept,
    input  logic [ctpr_pkg::RGB_W-1:0]        pixel_rgb,
    input  ctpr_pkg::dim_t                    w_eff,
    input  ctpr_pkg::dim_t                    h_eff,
    input  ctpr_pkg::entry_t                  rdata,
    output ctpr_pkg::col_t                    rd_addr,
    output ctpr_pkg::mem_wr_t                 wr
);

    localparam ctpr_pkg::dim_t ROW_LIMIT = ctpr_pkg::DIM_W'(ctpr_pkg::MAX_HEIGHT);

    ctpr_pkg::dim_t  row_reg,  row_next;
    ctpr_pkg::col_t  col_reg,  col_next;
    logic            s1_valid_reg, s1_valid_next;
    ctpr_pkg::col_t  s1_col_reg;
    logic [ctpr_pkg::TOP_W-1:0] s1_top_reg;
    logic            fw_valid_reg;
    ctpr_pkg::col_t  fw_col_reg;

    ctpr_pkg::col_t  col1;
    ctpr_pkg::dim_t  row1;
    ctpr_pkg::dim_t  col2;
    logic            cand;
    logic            found;
    logic            s1_write;

    // position of this pixel, wrapping first if the width was lowered
    always_comb
    begin
        if ({1'b0, col_reg} >= w_eff)
        begin
            col1 = '0;
            row1 = (row_reg < ROW_LIMIT) ? row_reg + 1'b1 : row_reg;
        end
        else
        begin
            col1 = col_reg;
            row1 = row_reg;
        end
        cand = (row1 < h_eff) && (pixel_rgb != '0);
        col2 = {1'b0, col1} + 1'b1;
    end

    // raster advance
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (clear_accept)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (pixel_accept)
        begin
            if (col2 >= w_eff)
            begin
                col_next = '0;
                row_next = (row1 < ROW_LIMIT) ? row1 + 1'b1 : row1;
            end
            else
            begin
                col_next = col2[ctpr_pkg::COL_W-1:0];
                row_next = row1;
            end
        end
    end

    assign s1_valid_next = pixel_accept && cand;
    assign rd_addr       = col1;

    // found check with forwarding of the write made in the previous cycle
    assign found    = rdata.found || (fw_valid_reg && (fw_col_reg == s1_col_reg));
    assign s1_write = s1_valid_reg && !found;

    always_comb
    begin
        wr.en         = s1_write;
        wr.addr       = s1_col_reg;
        wr.data.found = 1'b1;
        wr.data.top   = s1_top_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
            fw_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            s1_valid_reg <= s1_valid_next;
            fw_valid_reg <= s1_write;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_col_reg <= col1;
        s1_top_reg <= row1[ctpr_pkg::TOP_W-1:0];
        fw_col_reg <= s1_col_reg;
    end

endmodule

FILE: hw/rtl/ctpr_query.sv
// sample query sequencer: column mapping, two store reads, interpolation
module ctpr_query (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  query_accept,
    input  logic [ctpr_pkg::SAMPLE_W-1:0]         sample_index,
    input  ctpr_pkg::dim_t                        w_eff,
    input  ctpr_pkg::dim_t                        h_eff,
    input  ctpr_pkg::entry_t                      rdata,
    output ctpr_pkg::col_t                        rd_addr,
    output logic                                  query_busy,
    output logic                                  result_valid,
    output logic signed [ctpr_pkg::HEIGHT_W-1:0]  sample_height
);

    localparam logic [2:0] Q_IDLE = 3'd0;
    localparam logic [2:0] Q_MAP  = 3'd1;
    localparam logic [2:0] Q_RD0  = 3'd2;
    localparam logic [2:0] Q_RD1  = 3'd3;
    localparam logic [2:0] Q_MUL  = 3'd4;
    localparam logic [2:0] Q_SUM  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       valid_reg, valid_next;

    logic [ctpr_pkg::SAMPLE_W-1:0]        s_reg;
    ctpr_pkg::col_t                       c_reg;
    logic [ctpr_pkg::NS_LOG2-1:0]         r_reg;
    logic                                 last_reg;
    logic signed [ctpr_pkg::DHALF_W-1:0]  d0_reg;
    logic signed [ctpr_pkg::PROD_W-1:0]   prod_reg;
    logic signed [ctpr_pkg::HEIGHT_W-1:0] height_reg;

    logic [ctpr_pkg::PMAP_W-1:0]          p;
    ctpr_pkg::dim_t                       c_full;
    ctpr_pkg::dim_t                       wm1;
    ctpr_pkg::dim_t                       c_sel;
    logic [ctpr_pkg::NS_LOG2-1:0]         r_sel;
    logic signed [ctpr_pkg::DHALF_W-1:0]  d_now;
    logic signed [ctpr_pkg::DHALF_W-1:0]  diff;
    logic signed [ctpr_pkg::RFRAC_W-1:0]  r_s;
    logic signed [ctpr_pkg::PROD_W-1:0]   prod;
    logic signed [ctpr_pkg::SUM_W-1:0]    sum;
    logic signed [ctpr_pkg::HEIGHT_W-1:0] sat;

    // sample to column and fraction, clamped at the last column
    always_comb
    begin
        p      = ctpr_pkg::PMAP_W'(s_reg) * ctpr_pkg::PMAP_W'(w_eff);
        c_full = p[ctpr_pkg::PMAP_W-1:ctpr_pkg::NS_LOG2];
        wm1    = w_eff - 1'b1;
        if (c_full > wm1)
        begin
            c_sel = wm1;
            r_sel = '0;
        end
        else
        begin
            c_sel = c_full;
            r_sel = p[ctpr_pkg::NS_LOG2-1:0];
        end
    end

    // half-pixel height of the entry just read, slope times fraction
    assign d_now = ctpr_pkg::half_height(rdata, h_eff);
    assign diff  = d_now - d0_reg;
    assign r_s   = $signed({1'b0, r_reg});
    assign prod  = ctpr_pkg::PROD_W'(diff) * ctpr_pkg::PROD_W'(r_s);

    // base times sample count plus interpolation, then saturation
    always_comb
    begin
        sum = $signed({{(ctpr_pkg::SUM_W - ctpr_pkg::DHALF_W - ctpr_pkg::NS_LOG2)
                         {d0_reg[ctpr_pkg::DHALF_W-1]}},
                       d0_reg, {ctpr_pkg::NS_LOG2{1'b0}}})
            + $signed({prod_reg[ctpr_pkg::PROD_W-1], prod_reg});
        if (sum > ctpr_pkg::SUM_MAX)
        begin
            sat = ctpr_pkg::HEIGHT_W'(ctpr_pkg::SUM_MAX);
        end
        else if (sum < ctpr_pkg::SUM_MIN)
        begin
            sat = ctpr_pkg::HEIGHT_W'(ctpr_pkg::SUM_MIN);
        end
        else
        begin
            sat = sum[ctpr_pkg::HEIGHT_W-1:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        valid_next = 1'b0;
        case (state_reg)
            Q_IDLE:
            begin
                if (query_accept)
                begin
                    state_next = Q_MAP;
                end
            end
            Q_MAP:   state_next = Q_RD0;
            Q_RD0:   state_next = Q_RD1;
            Q_RD1:   state_next = Q_MUL;
            Q_MUL:   state_next = Q_SUM;
            Q_SUM:
            begin
                state_next = Q_IDLE;
                valid_next = 1'b1;
            end
            default: state_next = Q_IDLE;
        endcase
    end

    assign rd_addr    = (state_reg == Q_RD0) ? c_reg : c_reg + 1'b1;
    assign query_busy = (state_reg != Q_IDLE);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= Q_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (query_accept)
        begin
            s_reg <= sample_index;
        end
        if (state_reg == Q_MAP)
        begin
            c_reg    <= c_sel[ctpr_pkg::COL_W-1:0];
            r_reg    <= r_sel;
            last_reg <= (c_sel == wm1);
        end
        if (state_reg == Q_RD1)
        begin
            d0_reg <= d_now;
        end
        if (state_reg == Q_MUL)
        begin
            prod_reg <= last_reg ? '0 : prod;
        end
        if (state_reg == Q_SUM)
        begin
            height_reg <= sat;
        end
    end

    assign result_valid  = valid_reg;
    assign sample_height = height_reg;

endmodule

FILE: hw/rtl/column_top_profile_resampler.sv
// Column top profile resampler: takes an image as a raster pixel stream (top row first)
// and keeps, per column, the first row holding a non-black pixel in a 4096-entry column
// store. Pixel items are taken one per clock while busy is low; the store read happens
// in the accept cycle and the conditional write in the cycle after, with forwarding
// between back-to-back pixels of the same column. A clear item raises busy for a
// clearing pass over all 4096 entries of the column store, and the next item is taken
// once busy falls; the same pass runs after reset before the first item is taken. A
// sample query keeps busy high after it is taken for its steps (column mapping, two
// reads of the single store read port, the interpolation multiply and the final add),
// and the next item is taken once busy falls. Its result appears on sample_height,
// marked by result_valid for one cycle, in the first cycle with busy low again; the
// receiver cannot stall, so it must take every result when shown. Configuration must
// be written only while the block is idle; the block itself does not enforce this.
module column_top_profile_resampler (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic                                  cfg_index,
    input  logic [ctpr_pkg::DIM_W-1:0]            cfg_data,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            mode,
    input  logic [ctpr_pkg::RGB_W-1:0]            pixel_rgb,
    input  logic [ctpr_pkg::SAMPLE_W-1:0]         sample_index,
    output logic                                  result_valid,
    output logic signed [ctpr_pkg::HEIGHT_W-1:0]  sample_height
);

    localparam ctpr_pkg::dim_t WIDTH_LIMIT  = ctpr_pkg::DIM_W'(ctpr_pkg::MAX_WIDTH);
    localparam ctpr_pkg::dim_t HEIGHT_LIMIT = ctpr_pkg::DIM_W'(ctpr_pkg::MAX_HEIGHT);
    localparam ctpr_pkg::col_t SWEEP_LAST   = ctpr_pkg::COL_W'(ctpr_pkg::MAX_WIDTH - 1);

    ctpr_pkg::dim_t    width_reg,  width_next;
    ctpr_pkg::dim_t    height_reg, height_next;
    logic              sweep_reg,  sweep_next;
    ctpr_pkg::col_t    sweep_cnt_reg, sweep_cnt_next;

    ctpr_pkg::dim_t    w_eff;
    ctpr_pkg::dim_t    h_eff;
    logic              accept;
    logic              pixel_accept;
    logic              clear_accept;
    logic              query_accept;
    logic              query_busy;

    ctpr_pkg::col_t    px_rd_addr;
    ctpr_pkg::col_t    q_rd_addr;
    ctpr_pkg::mem_wr_t px_wr;
    ctpr_pkg::mem_wr_t mem_wr;
    ctpr_pkg::col_t    mem_raddr;
    logic [ctpr_pkg::ENTRY_W-1:0] mem_rdata;
    ctpr_pkg::entry_t  rd_entry;

    // configuration registers
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                ctpr_pkg::REG_WIDTH:  width_next  = cfg_data;
                ctpr_pkg::REG_HEIGHT: height_next = cfg_data;
                default:              width_next  = width_reg;
            endcase
        end
    end

    // effective image size
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = 13'd1;
        end
        else if (width_reg > WIDTH_LIMIT)
        begin
            w_eff = WIDTH_LIMIT;
        end
        else
        begin
            w_eff = width_reg;
        end
        if (height_reg == '0)
        begin
            h_eff = 13'd1;
        end
        else if (height_reg > HEIGHT_LIMIT)
        begin
            h_eff = HEIGHT_LIMIT;
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    // item decode
    assign busy         = sweep_reg || query_busy;
    assign accept       = start && !busy;
    assign pixel_accept = accept && (mode == ctpr_pkg::MODE_PIXEL);
    assign clear_accept = accept && (mode == ctpr_pkg::MODE_CLEAR);
    assign query_accept = accept && (mode == ctpr_pkg::MODE_QUERY);

    // clearing pass, a pending pixel write takes the port first
    always_comb
    begin
        sweep_next     = sweep_reg;
        sweep_cnt_next = sweep_cnt_reg;
        if (clear_accept)
        begin
            sweep_next     = 1'b1;
            sweep_cnt_next = '0;
        end
        else if (sweep_reg && !px_wr.en)
        begin
            sweep_cnt_next = sweep_cnt_reg + 1'b1;
            if (sweep_cnt_reg == SWEEP_LAST)
            begin
                sweep_next = 1'b0;
            end
        end
    end

    // column store port selection
    always_comb
    begin
        if (px_wr.en)
        begin
            mem_wr = px_wr;
        end
        else
        begin
            mem_wr.en         = sweep_reg;
            mem_wr.addr       = sweep_cnt_reg;
            mem_wr.data.found = 1'b0;
            mem_wr.data.top   = '0;
        end
        mem_raddr = query_busy ? q_rd_addr : px_rd_addr;
    end

    assign rd_entry = mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= ctpr_pkg::WIDTH_RESET;
            height_reg    <= ctpr_pkg::HEIGHT_RESET;
            sweep_reg     <= 1'b1;
            sweep_cnt_reg <= '0;
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            sweep_reg     <= sweep_next;
            sweep_cnt_reg <= sweep_cnt_next;
        end
    end

    // column store: found flag and first row per column
    ctpr_ram #(
        .WIDTH (ctpr_pkg::ENTRY_W),
        .DEPTH (ctpr_pkg::MAX_WIDTH)
    ) u_column_store (
        .clk   (clk),
        .we    (mem_wr.en),
        .waddr (mem_wr.addr),
        .wdata (mem_wr.data),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // pixel path
    ctpr_raster u_raster (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_accept (pixel_accept),
        .clear_accept (clear_accept),
        .pixel_rgb    (pixel_rgb),
        .w_eff        (w_eff),
        .h_eff        (h_eff),
        .rdata        (rd_entry),
        .rd_addr      (px_rd_addr),
        .wr           (px_wr)
    );

    // query path
    ctpr_query u_query (
        .clk           (clk),
        .rst_n         (rst_n),
        .query_accept  (query_accept),
        .sample_index  (sample_index),
        .w_eff         (w_eff),
        .h_eff         (h_eff),
        .rdata         (rd_entry),
        .rd_addr       (q_rd_addr),
        .query_busy    (query_busy),
        .result_valid  (result_valid),
        .sample_height (sample_height)
    );

endmodule
